// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL; empty in synthesis builds.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ----- sv/irn_pkg.sv -----
`timescale 1ns / 1ps
package irn_pkg;

  localparam int MAX_SIDE_DEF   = 256;
  localparam int PIXEL_BITS_DEF = 32;
  localparam int FRAC_BITS      = 14;
  localparam int CFG_ADDR_BITS  = 4;

  // register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_IMAGE_SIZE  = 2'd0;
  localparam logic [1:0] REG_COS_ANGLE   = 2'd1;
  localparam logic [1:0] REG_SIN_ANGLE   = 2'd2;
  localparam logic [1:0] REG_TRANSPARENT = 2'd3;

  localparam logic [8:0]  IMAGE_SIZE_RST  = 9'd256;
  localparam logic [15:0] COS_ANGLE_RST   = 16'h4000;
  localparam logic [15:0] SIN_ANGLE_RST   = 16'h0000;
  localparam logic [31:0] TRANSPARENT_RST = 32'h0000_0000;

  localparam logic ACTION_LOAD  = 1'b0;
  localparam logic ACTION_QUERY = 1'b1;

  // configuration seen by the datapath; angles are Q2.14 two's complement
  typedef struct packed {
    logic [8:0]  image_size;
    logic [15:0] cos_angle;
    logic [15:0] sin_angle;
    logic [31:0] transparent_color;
  } cfg_t;

  // rotation stage status, aligned with the rotated read address
  typedef struct packed {
    logic valid;
    logic ok;
  } rot_t;

  // linear pixel index: row-major with a fixed row pitch
  function automatic logic [31:0] pix_index(input logic [15:0] r, input logic [15:0] c,
                                            input int side);
    return 32'(r) * 32'(side) + 32'(c);
  endfunction

endpackage

// ----- sv/image_rotate_nearest.sv -----
`timescale 1ns / 1ps
// Nearest-neighbor image rotator. One item (load or query) is taken per clock
// cycle, every cycle; busy is high only during reset. A query's result appears
// on pixel_out/written with done high once the query has passed the v1, v2 and
// done registers, and stays for one cycle; the receiver cannot stall, so results
// must be captured when done is high. Loads give no result. The pipeline is
// set by the two pixel memories (one registered read each): first the mask
// pixel is read and the four products are formed, then the rotated address is
// formed and the source pixel read, and last the result is registered. The
// image is held twice, both copies written by each in-range load, so that a
// query gets both reads in flight at once; a load issued after a query never
// disturbs that query's reads. Image memory is not cleared: pixels are
// undefined until loaded. Configuration writes belong to idle periods.
`include "assert_macros.svh"
module image_rotate_nearest #(
  parameter int MAX_SIDE   = irn_pkg::MAX_SIDE_DEF,
  parameter int PIXEL_BITS = irn_pkg::PIXEL_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [irn_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              start,
  output logic                              busy,
  input  logic                              action,
  input  logic [7:0]                        row,
  input  logic [7:0]                        col,
  input  logic [31:0]                       pixel_in,
  output logic [PIXEL_BITS-1:0]             pixel_out,
  output logic                              written,
  output logic                              done
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);

  irn_pkg::cfg_t cfg;
  irn_pkg::rot_t rot;

  logic                  accept;
  logic                  query_accept;
  logic                  load_we;
  logic [AW-1:0]         src_addr;
  logic [AW-1:0]         rot_addr;
  logic [PIXEL_BITS-1:0] mask_pix;
  logic [PIXEL_BITS-1:0] src_pix;
  logic                  transp;

  irn_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // accept a transfer whenever out of reset
  assign busy         = rst;
  assign accept       = start && !busy;
  assign query_accept = accept && (action == irn_pkg::ACTION_QUERY);
  assign load_we      = accept && (action == irn_pkg::ACTION_LOAD) &&
                        (32'(row) < 32'(MAX_SIDE)) && (32'(col) < 32'(MAX_SIDE));
  assign src_addr     = AW'(irn_pkg::pix_index(16'(row), 16'(col), MAX_SIDE));

  // copy used for the transparency mask at the destination position
  irn_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_mask_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (src_addr),
    .wdata (pixel_in[PIXEL_BITS-1:0]),
    .raddr (src_addr),
    .rdata (mask_pix)
  );

  irn_rotate #(.MAX_SIDE(MAX_SIDE)) u_rotate (
    .clk      (clk),
    .rst      (rst),
    .query    (query_accept),
    .row      (row),
    .col      (col),
    .cfg      (cfg),
    .rot_addr (rot_addr),
    .rot      (rot)
  );

  // copy read at the rotated source coordinate
  irn_ram #(.WIDTH(PIXEL_BITS), .DEPTH(DEPTH)) u_src_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (src_addr),
    .wdata (pixel_in[PIXEL_BITS-1:0]),
    .raddr (rot_addr),
    .rdata (src_pix)
  );

  assign transp = (mask_pix == cfg.transparent_color[PIXEL_BITS-1:0]);

  logic v2;
  logic ok2;

  // hold the query status while the source pixel is read
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= rot.valid;
    end
  end

  always_ff @(posedge clk) begin
    ok2 <= rot.ok && !transp;
  end

  // register the result; a query that is not written gives a zero pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v2;
    end
  end

  always_ff @(posedge clk) begin
    written   <= v2 && ok2;
    pixel_out <= ok2 ? src_pix : '0;
  end

  `ASSERT_IMPLY(a_done_has_query, clk, rst, done, $past(query_accept, 3))
  `ASSERT_IMPLY(a_query_gives_done, clk, rst, $past(query_accept, 3) && !$past(rst, 1) && !$past(rst, 2), done)
  `ASSERT_IMPLY(a_unwritten_zero, clk, rst, done && !written, pixel_out == '0)

endmodule

// ----- sv/irn_ram.sv -----
`timescale 1ns / 1ps
module irn_ram #(
  parameter int WIDTH = irn_pkg::PIXEL_BITS_DEF,
  parameter int DEPTH = irn_pkg::MAX_SIDE_DEF * irn_pkg::MAX_SIDE_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read; a read at the written address returns old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- sv/irn_cfg.sv -----
`timescale 1ns / 1ps
module irn_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [irn_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output irn_pkg::cfg_t                      cfg
);

  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;

  // update registers on a completed write transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_size        <= irn_pkg::IMAGE_SIZE_RST;
      cfg.cos_angle         <= irn_pkg::COS_ANGLE_RST;
      cfg.sin_angle         <= irn_pkg::SIN_ANGLE_RST;
      cfg.transparent_color <= irn_pkg::TRANSPARENT_RST;
    end else if (wr) begin
      unique case (idx)
        irn_pkg::REG_IMAGE_SIZE:  cfg.image_size        <= pwdata[8:0];
        irn_pkg::REG_COS_ANGLE:   cfg.cos_angle         <= pwdata[15:0];
        irn_pkg::REG_SIN_ANGLE:   cfg.sin_angle         <= pwdata[15:0];
        irn_pkg::REG_TRANSPARENT: cfg.transparent_color <= pwdata;
      endcase
    end
  end

  // read back the addressed register
  always_comb begin
    unique case (idx)
      irn_pkg::REG_IMAGE_SIZE:  prdata = 32'(cfg.image_size);
      irn_pkg::REG_COS_ANGLE:   prdata = 32'(cfg.cos_angle);
      irn_pkg::REG_SIN_ANGLE:   prdata = 32'(cfg.sin_angle);
      irn_pkg::REG_TRANSPARENT: prdata = cfg.transparent_color;
    endcase
  end

endmodule

// ----- sv/irn_rotate.sv -----
`timescale 1ns / 1ps
module irn_rotate #(
  parameter int MAX_SIDE = irn_pkg::MAX_SIDE_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   query,
  input  logic [7:0]                             row,
  input  logic [7:0]                             col,
  input  irn_pkg::cfg_t                          cfg,
  output logic [$clog2(MAX_SIDE*MAX_SIDE)-1:0]   rot_addr,
  output irn_pkg::rot_t                          rot
);

  localparam int AW = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int SW = $clog2(MAX_SIDE + 1);
  localparam int CW = (SW > 9) ? SW : 9;
  localparam int TW = CW + 1;
  localparam int PW = TW + 16;
  localparam int QW = PW + 2;
  localparam logic signed [QW-1:0] ROUND = QW'((1 << irn_pkg::FRAC_BITS) - 1);
  localparam logic signed [QW-1:0] ZERO  = '0;

  // divide by 2^FRAC_BITS, truncating toward zero
  function automatic logic signed [QW-1:0] trunc_frac(input logic signed [QW-1:0] v);
    logic signed [QW-1:0] bias;
    bias = v[QW-1] ? ROUND : ZERO;
    return (v + bias) >>> irn_pkg::FRAC_BITS;
  endfunction

  logic [CW-1:0]          size_raw;
  logic [SW-1:0]          size0;
  logic [SW-1:0]          half0;
  logic                   in_image0;
  logic signed [TW-1:0]   tr0;
  logic signed [TW-1:0]   tc0;
  logic signed [15:0]     cos_s;
  logic signed [15:0]     sin_s;

  // clamp the side, center the destination coordinate
  always_comb begin
    cos_s     = $signed(cfg.cos_angle);
    sin_s     = $signed(cfg.sin_angle);
    size_raw  = CW'(cfg.image_size);
    size0     = (size_raw > CW'(MAX_SIDE)) ? SW'(MAX_SIDE) : SW'(cfg.image_size);
    half0     = size0 >> 1;
    in_image0 = (CW'(row) < CW'(size0)) && (CW'(col) < CW'(size0));
    tr0       = TW'(row) - TW'(half0);
    tc0       = TW'(col) - TW'(half0);
  end

  logic                 v1;
  logic                 in_image1;
  logic [SW-1:0]        size1;
  logic [SW-1:0]        half1;
  logic signed [PW-1:0] p_rc1;
  logic signed [PW-1:0] p_cs1;
  logic signed [PW-1:0] p_rs1;
  logic signed [PW-1:0] p_cc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= query;
    end
  end

  // register the four products
  always_ff @(posedge clk) begin
    in_image1 <= in_image0;
    size1     <= size0;
    half1     <= half0;
    p_rc1     <= tr0 * cos_s;
    p_cs1     <= tc0 * sin_s;
    p_rs1     <= tr0 * sin_s;
    p_cc1     <= tc0 * cos_s;
  end

  logic signed [QW-1:0] sum_r;
  logic signed [QW-1:0] sum_c;
  logic signed [QW-1:0] half_s;
  logic signed [QW-1:0] size_s;
  logic signed [QW-1:0] rr;
  logic signed [QW-1:0] rc;

  // combine, truncate, recenter and range-check the source coordinate
  always_comb begin
    sum_r    = p_rc1 - p_cs1;
    sum_c    = p_rs1 + p_cc1;
    half_s   = QW'(half1);
    size_s   = QW'(size1);
    rr       = trunc_frac(sum_r) + half_s;
    rc       = trunc_frac(sum_c) + half_s;
    rot.valid = v1;
    rot.ok    = in_image1 && (rr > ZERO) && (rr < size_s) && (rc > ZERO) && (rc < size_s);
    rot_addr  = AW'(irn_pkg::pix_index(16'(rr[SW-1:0]), 16'(rc[SW-1:0]), MAX_SIDE));
  end

endmodule
